// File: design/tpd_pkg.sv
// ----------------------------------------------------------------------------
// Telemetry packet decoder package
// Shared types and constants for the telemetry packet decoder: frame codes,
// sensor ids, unit codes and the records passed between the decoder parts.
// ----------------------------------------------------------------------------
`default_nettype none

package tpd_pkg;

  // Packet geometry.
  localparam int unsigned PktLen = 8;

  // Start-of-packet rule: 0x00 or anything at or above this value.
  localparam logic [7:0] StartMin = 8'hAC;

  // Frame numbers carried in packet byte 2.
  localparam logic [7:0] FrameBatt   = 8'h00;
  localparam logic [7:0] FrameRxVolt = 8'h11;
  localparam logic [7:0] FrameNone0  = 8'h12;
  localparam logic [7:0] FrameTemp   = 8'h13;
  localparam logic [7:0] FrameGps    = 8'h14;
  localparam logic [7:0] FrameRpm    = 8'h15;
  localparam logic [7:0] FrameNone1  = 8'h16;
  localparam logic [7:0] FrameMisc   = 8'h17;
  localparam logic [7:0] FrameAmp    = 8'h18;

  // Sensor identifiers.
  localparam logic [15:0] IdRssi     = 16'hFF00;
  localparam logic [15:0] IdLqi      = 16'hFF01;
  localparam logic [15:0] IdBatt     = 16'h0003;
  localparam logic [15:0] IdRxVolt   = 16'h1103;
  localparam logic [15:0] IdTemp     = 16'h1304;
  localparam logic [15:0] IdSpeed    = 16'h1400;
  localparam logic [15:0] IdAlt      = 16'h1402;
  localparam logic [15:0] IdGpsTemp  = 16'h1404;
  localparam logic [15:0] IdRpmRaw   = 16'h1500;
  localparam logic [15:0] IdRpm1     = 16'h1501;
  localparam logic [15:0] IdRpm2     = 16'h1503;
  localparam logic [15:0] IdMiscRaw0 = 16'h1700;
  localparam logic [15:0] IdMiscRaw1 = 16'h1702;
  localparam logic [15:0] IdMiscT1   = 16'h1703;
  localparam logic [15:0] IdMiscT2   = 16'h1704;
  localparam logic [15:0] IdVolt     = 16'h1800;
  localparam logic [15:0] IdAmp      = 16'h1803;

  // Scaled value: word * 100 / 28 == word * 25 / 7, and word * 100 / 14 == word * 50 / 7.
  localparam int unsigned ScaledW    = 22;
  localparam logic [ScaledW-1:0] ScaleVolt = 22'd25;
  localparam logic [ScaledW-1:0] ScaleAmp  = 22'd50;
  localparam logic [7:0] TempOffset = 8'd40;

  // Reciprocal of 7 in 24 fractional bits, rounded down.
  localparam int unsigned RecipShift = 24;
  localparam logic [ScaledW-1:0] Recip7 = 22'd2396745;
  localparam int unsigned QuotW = 20;

  typedef enum logic [2:0] {
    UNIT_NONE  = 3'd0,
    UNIT_VOLT  = 3'd1,
    UNIT_CELS  = 3'd2,
    UNIT_SPEED = 3'd3,
    UNIT_METER = 3'd4,
    UNIT_RPM   = 3'd5,
    UNIT_AMP   = 3'd6
  } tpd_unit_e;

  // One complete packet plus its pre-scaled divider operand.
  typedef struct packed {
    logic [ScaledW-1:0]     scaled;
    logic [PktLen-1:0][7:0] bytes;
  } tpd_pkt_t;

  // One result item.
  typedef struct packed {
    logic [15:0] sensor_id;
    logic [31:0] reading;
    tpd_unit_e   unit_code;
    logic [1:0]  decimals;
    logic        link_alive;
    logic        last;
  } tpd_result_t;

endpackage

`default_nettype wire

// File: design/tpd_front.sv
// ----------------------------------------------------------------------------
// Telemetry packet decoder front end
// Accepts received bytes, drops invalid start bytes, gathers eight bytes and
// pushes each complete packet, with its scaled voltage word, to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tpd_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      rx_byte_i,
  output logic                 push_o,
  output tpd_pkg::tpd_pkt_t    push_data_o,
  input  wire logic            push_ready_i
);

  localparam logic [2:0] LastIdx = 3'(tpd_pkg::PktLen - 1);

  logic [2:0]                           count_q, count_d;
  logic [tpd_pkg::PktLen-2:0][7:0]      buf_q;
  logic                                 accept;
  logic                                 start_ok;
  logic [15:0]                          volt_word;
  logic [tpd_pkg::ScaledW-1:0]          scale;

  // Only the final byte needs queue space.
  assign in_ready_o = (count_q != LastIdx) || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign start_ok   = (count_q != 3'd0) || (rx_byte_i == 8'h00) ||
                      (rx_byte_i >= tpd_pkg::StartMin);

  // Packet completes with the eighth byte of a started packet.
  assign push_o = accept && (count_q == LastIdx);

  // Assemble the packet with the arriving byte in the last place.
  assign volt_word = {buf_q[6], rx_byte_i};
  assign scale     = (buf_q[2] == tpd_pkg::FrameAmp) ? tpd_pkg::ScaleAmp
                                                     : tpd_pkg::ScaleVolt;
  always_comb begin
    push_data_o.bytes  = {rx_byte_i, buf_q};
    push_data_o.scaled = {6'd0, volt_word} * scale;
  end

  // Byte counter.
  always_comb begin
    count_d = count_q;
    if (accept && start_ok) begin
      count_d = (count_q == LastIdx) ? 3'd0 : count_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 3'd0;
    end else begin
      count_q <= count_d;
    end
  end

  // Byte buffer; the last byte goes straight into the pushed packet.
  always_ff @(posedge clk_i) begin
    if (accept && start_ok && (count_q != LastIdx)) begin
      buf_q[count_q] <= rx_byte_i;
    end
  end

endmodule

`default_nettype wire

// File: design/tpd_queue.sv
// ----------------------------------------------------------------------------
// Telemetry packet decoder packet queue
// Small register FIFO of complete packets between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tpd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_valid_i,
  output logic                    wr_ready_o,
  input  wire tpd_pkg::tpd_pkt_t  wr_data_i,
  output logic                    rd_valid_o,
  input  wire logic               rd_ready_i,
  output tpd_pkg::tpd_pkt_t       rd_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  tpd_pkg::tpd_pkt_t mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_wr, do_rd;

  assign wr_ready_o = (cnt_q != Full);
  assign rd_valid_o = (cnt_q != '0);
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// File: design/tpd_div7.sv
// ----------------------------------------------------------------------------
// Telemetry packet decoder divide-by-seven unit
// Two-stage pipeline: reciprocal multiply, then one compare-and-correct step.
// ----------------------------------------------------------------------------
`default_nettype none

module tpd_div7 (
  input  wire logic                          clk_i,
  input  wire logic [tpd_pkg::ScaledW-1:0]   x_i,
  output logic      [tpd_pkg::QuotW-1:0]     q_o
);

  localparam int unsigned W = tpd_pkg::ScaledW;
  localparam int unsigned QW = tpd_pkg::QuotW;

  logic [2*W-1:0] prod_q;
  logic [W-1:0]   x_q;
  logic [QW-1:0]  q0;
  logic [W-1:0]   rem;
  logic [QW-1:0]  q_q;

  // The estimate is the true quotient or one below it.
  assign q0  = prod_q[tpd_pkg::RecipShift +: QW];
  assign rem = x_q - ((W'(q0) << 3) - W'(q0));
  assign q_o = q_q;

  always_ff @(posedge clk_i) begin
    prod_q <= {{W{1'b0}}, x_i} * {{W{1'b0}}, tpd_pkg::Recip7};
    x_q    <= x_i;
    q_q    <= (rem >= W'(7)) ? q0 + 1'b1 : q0;
  end

endmodule

`default_nettype wire

// File: design/tpd_back.sv
// ----------------------------------------------------------------------------
// Telemetry packet decoder back end
// Takes one packet at a time from the queue and emits its RSSI, LQI and
// sensor results through an output register, one per cycle while that register can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module tpd_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               pkt_valid_i,
  output logic                    pkt_ready_o,
  input  wire tpd_pkg::tpd_pkt_t  pkt_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output tpd_pkg::tpd_result_t    out_data_o
);

  tpd_pkg::tpd_pkt_t    pkt_q;
  tpd_pkg::tpd_result_t out_q;
  tpd_pkg::tpd_result_t res;
  logic                 busy_q, out_valid_q;
  logic [2:0]           slot_q;
  logic [2:0]           n_res;
  logic [1:0]           sens;
  logic                 advance, is_last, load;
  logic [tpd_pkg::QuotW-1:0] quot;
  logic [7:0]           p [tpd_pkg::PktLen];

  // The divider registers the product, then the corrected quotient; the first
  // sensor result follows the RSSI and LQI results.
  tpd_div7 u_div7 (
    .clk_i (clk_i),
    .x_i   (pkt_q.scaled),
    .q_o   (quot)
  );

  always_comb begin
    for (int i = 0; i < tpd_pkg::PktLen; i++) begin
      p[i] = pkt_q.bytes[i];
    end
  end

  // Number of results for the frame: RSSI and LQI plus its sensors.
  always_comb begin
    unique case (p[2]) inside
      tpd_pkg::FrameNone0, tpd_pkg::FrameNone1: n_res = 3'd2;
      tpd_pkg::FrameGps, tpd_pkg::FrameRpm:     n_res = 3'd5;
      tpd_pkg::FrameMisc:                       n_res = 3'd6;
      tpd_pkg::FrameAmp:                        n_res = 3'd4;
      default:                                  n_res = 3'd3;
    endcase
  end

  // Result for the current slot.
  always_comb begin
    sens           = 2'(slot_q - 3'd2);
    res            = '0;
    res.unit_code  = tpd_pkg::UNIT_NONE;
    res.last       = is_last;
    if (slot_q == 3'd0) begin
      res.sensor_id  = tpd_pkg::IdRssi;
      res.reading    = {24'd0, p[0]};
      res.link_alive = (p[0] != 8'd0);
    end else if (slot_q == 3'd1) begin
      res.sensor_id = tpd_pkg::IdLqi;
      res.reading   = {24'd0, p[1]};
    end else begin
      unique case (p[2]) inside
        tpd_pkg::FrameBatt, tpd_pkg::FrameRxVolt: begin
          res.sensor_id = (p[2] == tpd_pkg::FrameBatt) ? tpd_pkg::IdBatt
                                                       : tpd_pkg::IdRxVolt;
          res.reading   = {12'd0, quot};
          res.unit_code = tpd_pkg::UNIT_VOLT;
          res.decimals  = 2'd2;
        end
        tpd_pkg::FrameNone0, tpd_pkg::FrameNone1: begin
          res.sensor_id = '0;
        end
        tpd_pkg::FrameTemp: begin
          res.sensor_id = tpd_pkg::IdTemp;
          res.reading   = {24'd0, p[7]} - {24'd0, tpd_pkg::TempOffset};
          res.unit_code = tpd_pkg::UNIT_CELS;
        end
        tpd_pkg::FrameGps: begin
          case (sens)
            2'd0: begin
              res.sensor_id = tpd_pkg::IdSpeed;
              res.reading   = {16'd0, p[3], p[4]};
              res.unit_code = tpd_pkg::UNIT_SPEED;
            end
            2'd1: begin
              res.sensor_id = tpd_pkg::IdAlt;
              res.reading   = {16'd0, p[5], p[6]};
              res.unit_code = tpd_pkg::UNIT_METER;
            end
            default: begin
              res.sensor_id = tpd_pkg::IdGpsTemp;
              res.reading   = {24'd0, p[7]} - {24'd0, tpd_pkg::TempOffset};
              res.unit_code = tpd_pkg::UNIT_CELS;
            end
          endcase
        end
        tpd_pkg::FrameRpm: begin
          case (sens)
            2'd0: begin
              res.sensor_id = tpd_pkg::IdRpmRaw;
              res.reading   = {24'd0, p[3]};
            end
            2'd1: begin
              res.sensor_id = tpd_pkg::IdRpm1;
              res.reading   = {16'd0, p[5], p[4]};
              res.unit_code = tpd_pkg::UNIT_RPM;
            end
            default: begin
              res.sensor_id = tpd_pkg::IdRpm2;
              res.reading   = {16'd0, p[7], p[6]};
              res.unit_code = tpd_pkg::UNIT_RPM;
            end
          endcase
        end
        tpd_pkg::FrameMisc: begin
          case (sens)
            2'd0: begin
              res.sensor_id = tpd_pkg::IdMiscRaw0;
              res.reading   = {16'd0, p[3], p[4]};
            end
            2'd1: begin
              res.sensor_id = tpd_pkg::IdMiscRaw1;
              res.reading   = {24'd0, p[5]};
            end
            2'd2: begin
              res.sensor_id = tpd_pkg::IdMiscT1;
              res.reading   = {24'd0, p[6]} - {24'd0, tpd_pkg::TempOffset};
              res.unit_code = tpd_pkg::UNIT_CELS;
            end
            default: begin
              res.sensor_id = tpd_pkg::IdMiscT2;
              res.reading   = {24'd0, p[7]} - {24'd0, tpd_pkg::TempOffset};
              res.unit_code = tpd_pkg::UNIT_CELS;
            end
          endcase
        end
        tpd_pkg::FrameAmp: begin
          if (sens == 2'd0) begin
            res.sensor_id = tpd_pkg::IdVolt;
            res.reading   = {16'd0, p[4], p[5]};
            res.unit_code = tpd_pkg::UNIT_VOLT;
            res.decimals  = 2'd1;
          end else begin
            res.sensor_id = tpd_pkg::IdAmp;
            res.reading   = {12'd0, quot};
            res.unit_code = tpd_pkg::UNIT_AMP;
            res.decimals  = 2'd2;
          end
        end
        default: begin
          res.sensor_id = {8'd0, p[2]};
          res.reading   = {p[6], p[5], p[4], p[3]};
        end
      endcase
    end
  end

  // Sequencing: one result per cycle while the output register can take it.
  assign advance     = busy_q && (!out_valid_q || out_ready_i);
  assign is_last     = (slot_q == n_res - 3'd1);
  assign pkt_ready_o = !busy_q || (advance && is_last);
  assign load        = pkt_valid_i && pkt_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      slot_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // A new packet restarts the slot count; otherwise each result steps it.
      if (load) begin
        busy_q <= 1'b1;
        slot_q <= 3'd0;
      end else if (advance) begin
        slot_q <= slot_q + 3'd1;
        if (is_last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (load) begin
      pkt_q <= pkt_data_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

// File: design/telemetry_packet_decoder.sv
// ----------------------------------------------------------------------------
// Telemetry packet decoder
// Gathers received bytes into 8-byte packets and emits RSSI, LQI and decoded
// sensor results for each packet.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | in_valid_i / in_ready_o | rx_byte_i
//   out     | output    | out_valid_o/out_ready_i | sensor_id_o, reading_o,
//           |           |                         | unit_code_o, decimals_o,
//           |           |                         | link_alive_o, last_o
//
// One byte is accepted every cycle while in_ready_o is high. A packet's results
// (two to six) leave one per cycle unless out_ready_i holds them, after the queue,
// packet register and output register; the back end's sequencer sets the rate.
// Reset clears the byte count, the packet queue and the result sequencer.
// in_ready_o drops only while the eighth byte waits for a free queue entry;
// out_ready_i low holds the current result and later packets in the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module telemetry_packet_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         rx_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [15:0]             sensor_id_o,
  output logic signed [31:0]      reading_o,
  output logic [2:0]              unit_code_o,
  output logic [1:0]              decimals_o,
  output logic                    link_alive_o,
  output logic                    last_o
);

  logic                 push_valid, push_ready;
  tpd_pkg::tpd_pkt_t    push_data;
  logic                 pop_valid, pop_ready;
  tpd_pkg::tpd_pkt_t    pop_data;
  tpd_pkg::tpd_result_t result;

  // Byte gathering.
  tpd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .push_o       (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  // Packet queue.
  tpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_data),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (pop_data)
  );

  // Result generation.
  tpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_valid_i (pop_valid),
    .pkt_ready_o (pop_ready),
    .pkt_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (result)
  );

  assign sensor_id_o  = result.sensor_id;
  assign reading_o    = $signed(result.reading);
  assign unit_code_o  = result.unit_code;
  assign decimals_o   = result.decimals;
  assign link_alive_o = result.link_alive;
  assign last_o       = result.last;

`ifndef NO_ASSERTIONS
  // Only the RSSI result can report a live link.
  a_alive_rssi : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && link_alive_o |-> sensor_id_o == tpd_pkg::IdRssi)
    else $error("link_alive set on a non-RSSI result");

  // The RSSI result always opens a packet and never closes it.
  a_rssi_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sensor_id_o == tpd_pkg::IdRssi && decimals_o == 2'd0 &&
    unit_code_o == tpd_pkg::UNIT_NONE |-> !last_o)
    else $error("RSSI result marked last");

  // The front end stalls only when the queue cannot take a packet.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> !push_ready)
    else $error("input stalled while the queue has room");

  // A packet is only pushed when the queue has room.
  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> push_ready)
    else $error("packet pushed into a full queue");
`endif

endmodule

`default_nettype wire
